[design/slv3_pkg.sv]
// Shared types and constants for the 3x3 linear solve core.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps
package slv3_pkg;

  localparam int DW      = 24;              // input field width, Q12.12
  localparam int ADJ_W   = 2 * DW + 1;      // adjugate element width
  localparam int LO_W    = DW + 1;          // low slice of an adjugate element
  localparam int HI_W    = ADJ_W - LO_W;    // high slice of an adjugate element
  localparam int PROD_W  = DW + ADJ_W;      // one full product of 24 by 49 bits
  localparam int SUM_W   = PROD_W + 2;      // sum of three products
  localparam int FRAC_SH = 17;              // 16 fraction bits plus one for rounding
  localparam int Q_W     = 33;              // quotient bits produced by the divider
  localparam int DIV_W   = SUM_W + Q_W + 2; // divider datapath width
  localparam int BW      = 32;              // result width, Q16.16

  typedef logic [8:0][DW-1:0]    hmat_t;
  typedef logic [2:0][DW-1:0]    vec3_t;
  typedef logic [8:0][ADJ_W-1:0] adjm_t;

  typedef struct packed {
    logic [BW-1:0] b;
    logic          ovf;
    logic          sing;
  } lane_res_t;

  // Cofactor k is h[AI]*h[AJ] - h[BI]*h[BJ].
  localparam int ADJ_AI[9] = '{4, 2, 1, 5, 0, 2, 3, 1, 0};
  localparam int ADJ_AJ[9] = '{8, 7, 5, 6, 8, 3, 7, 6, 4};
  localparam int ADJ_BI[9] = '{5, 1, 2, 3, 2, 0, 4, 0, 1};
  localparam int ADJ_BJ[9] = '{7, 8, 4, 8, 6, 5, 6, 7, 3};

endpackage

[design/slv3_adj.sv]
// Adjugate stages: 18 products of matrix entries, then the nine differences.
// Depends on slv3_pkg.
`timescale 1ns / 1ps
module slv3_adj (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            in_valid,
  input  slv3_pkg::hmat_t h,
  input  slv3_pkg::vec3_t d,
  output logic            out_valid,
  output slv3_pkg::adjm_t adj,
  output slv3_pkg::vec3_t hrow,
  output slv3_pkg::vec3_t dvec
);
  import slv3_pkg::*;

  logic signed [2*DW-1:0] pa_r [9];
  logic signed [2*DW-1:0] pb_r [9];
  logic  v1_r, v2_r;
  vec3_t hrow1_r, d1_r, hrow_r, d_r;
  adjm_t adj_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 9; k++) begin
        pa_r[k]  <= $signed(h[ADJ_AI[k]]) * $signed(h[ADJ_AJ[k]]);
        pb_r[k]  <= $signed(h[ADJ_BI[k]]) * $signed(h[ADJ_BJ[k]]);
        adj_r[k] <= {pa_r[k][2*DW-1], pa_r[k]} - {pb_r[k][2*DW-1], pb_r[k]};
      end
      hrow1_r <= {h[2], h[1], h[0]};
      d1_r    <= d;
      hrow_r  <= hrow1_r;
      d_r     <= d1_r;
    end
  end

  assign out_valid = v2_r;
  assign adj       = adj_r;
  assign hrow      = hrow_r;
  assign dvec      = d_r;

endmodule

[design/slv3_mac.sv]
// Determinant and numerator stages: split products, recombination, three-term sums.
// Depends on slv3_pkg.
`timescale 1ns / 1ps
module slv3_mac (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             en,
  input  logic                             in_valid,
  input  slv3_pkg::adjm_t                  adj,
  input  slv3_pkg::vec3_t                  hrow,
  input  slv3_pkg::vec3_t                  dvec,
  output logic                             out_valid,
  output logic [slv3_pkg::SUM_W-1:0]       det,
  output logic [2:0][slv3_pkg::SUM_W-1:0]  num
);
  import slv3_pkg::*;

  // Terms 0..2 form the determinant, terms 3..11 the numerators (row by row).
  logic signed [DW+LO_W:0]  plo_r [12];
  logic signed [DW+HI_W-1:0] phi_r [12];
  logic        [PROD_W-1:0] prod_r [12];
  logic        [SUM_W-1:0]  det_r;
  logic [2:0][SUM_W-1:0]    num_r;
  logic v3_r, v4_r, v5_r;
  logic [DW-1:0]    xs [12];
  logic [ADJ_W-1:0] as [12];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      xs[k] = hrow[k];
      as[k] = adj[3 * k];
    end
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        xs[3 + 3 * i + j] = dvec[j];
        as[3 + 3 * i + j] = adj[3 * i + j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else if (en) begin
      v3_r <= in_valid;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 12; k++) begin
        plo_r[k]  <= $signed(xs[k]) * $signed({1'b0, as[k][LO_W-1:0]});
        phi_r[k]  <= $signed(xs[k]) * $signed(as[k][ADJ_W-1:LO_W]);
        prod_r[k] <= {phi_r[k], {LO_W{1'b0}}}
                   + {{(PROD_W-DW-LO_W-1){plo_r[k][DW+LO_W]}}, plo_r[k]};
      end
      det_r <= {{2{prod_r[0][PROD_W-1]}}, prod_r[0]}
             + {{2{prod_r[1][PROD_W-1]}}, prod_r[1]}
             + {{2{prod_r[2][PROD_W-1]}}, prod_r[2]};
      for (int i = 0; i < 3; i++) begin
        num_r[i] <= {{2{prod_r[3+3*i][PROD_W-1]}}, prod_r[3+3*i]}
                  + {{2{prod_r[4+3*i][PROD_W-1]}}, prod_r[4+3*i]}
                  + {{2{prod_r[5+3*i][PROD_W-1]}}, prod_r[5+3*i]};
      end
    end
  end

  assign out_valid = v5_r;
  assign det       = det_r;
  assign num       = num_r;

endmodule

[design/slv3_div.sv]
// One solution lane: magnitude and rounding set-up, range check, a restoring divider of one
// quotient bit per stage, then saturation and sign. Depends on slv3_pkg.
`timescale 1ns / 1ps
module slv3_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic                       in_valid,
  input  logic [slv3_pkg::SUM_W-1:0] num,
  input  logic [slv3_pkg::SUM_W-1:0] det,
  output logic                       out_valid,
  output slv3_pkg::lane_res_t        res
);
  import slv3_pkg::*;

  localparam logic [Q_W-1:0] LIM_POS = Q_W'((64'd1 << (BW - 1)) - 64'd1);
  localparam logic [Q_W-1:0] LIM_NEG = Q_W'(64'd1 << (BW - 1));

  logic [SUM_W-1:0] an, ad;
  logic             p1_v_r, p1_neg_r, p1_sing_r;
  logic [DIV_W-1:0] p1_nn_r, p1_dd_r;

  logic             v_r    [Q_W+1];
  logic [DIV_W-1:0] rem_r  [Q_W+1];
  logic [DIV_W-1:0] dd_r   [Q_W+1];
  logic [Q_W-1:0]   q_r    [Q_W+1];
  logic             neg_r  [Q_W+1];
  logic             sing_r [Q_W+1];
  logic             pre_r  [Q_W+1];

  logic             vout_r;
  lane_res_t        res_r;
  logic [Q_W-1:0]   lim, mag;
  logic             sat;

  assign an = num[SUM_W-1] ? (~num + 1'b1) : num;
  assign ad = det[SUM_W-1] ? (~det + 1'b1) : det;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_v_r <= 1'b0;
      v_r[0] <= 1'b0;
    end else if (en) begin
      p1_v_r <= in_valid;
      v_r[0] <= p1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_neg_r  <= (num[SUM_W-1] == det[SUM_W-1]);
      p1_sing_r <= (det == '0);
      p1_nn_r   <= {{(DIV_W-SUM_W-FRAC_SH){1'b0}}, an, {FRAC_SH{1'b0}}}
                 + {{(DIV_W-SUM_W){1'b0}}, ad};
      p1_dd_r   <= {{(DIV_W-SUM_W-1){1'b0}}, ad, 1'b0};
      // Quotient of 2^Q_W or more cannot fit and saturates regardless.
      pre_r[0]  <= (p1_nn_r >= (p1_dd_r << Q_W));
      rem_r[0]  <= p1_nn_r;
      dd_r[0]   <= p1_dd_r;
      q_r[0]    <= '0;
      neg_r[0]  <= p1_neg_r;
      sing_r[0] <= p1_sing_r;
    end
  end

  for (genvar k = 1; k <= Q_W; k++) begin : g_stage
    logic [DIV_W-1:0] cmp;
    logic             ge;
    assign cmp = dd_r[k-1] << (Q_W - k);
    assign ge  = (rem_r[k-1] >= cmp);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= v_r[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= ge ? (rem_r[k-1] - cmp) : rem_r[k-1];
        q_r[k]    <= {q_r[k-1][Q_W-2:0], ge};
        dd_r[k]   <= dd_r[k-1];
        neg_r[k]  <= neg_r[k-1];
        sing_r[k] <= sing_r[k-1];
        pre_r[k]  <= pre_r[k-1];
      end
    end
  end

  assign lim = neg_r[Q_W] ? LIM_NEG : LIM_POS;
  assign sat = pre_r[Q_W] || (q_r[Q_W] > lim);
  assign mag = sat ? lim : q_r[Q_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vout_r <= 1'b0;
    end else if (en) begin
      vout_r <= v_r[Q_W];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (sing_r[Q_W]) begin
        res_r.b   <= '0;
        res_r.ovf <= 1'b0;
      end else begin
        res_r.b   <= neg_r[Q_W] ? (~mag[BW-1:0] + 1'b1) : mag[BW-1:0];
        res_r.ovf <= sat;
      end
      res_r.sing <= sing_r[Q_W];
    end
  end

  assign out_valid = vout_r;
  assign res       = res_r;

endmodule

[design/solve_3x3_linear_system_core.sv]
// Top level of the 3x3 linear solve core (B = -inverse(H) * D by Cramer's rule).
// Depends on slv3_pkg, slv3_adj, slv3_mac and slv3_div.
`timescale 1ns / 1ps
// Usage
// The input channel carries one matrix H (row-major, nine Q12.12 entries) and one
// vector D (three Q12.12 entries) per transaction. The result channel returns one
// transaction per input: the three Q16.16 solution elements, rounded to nearest
// with ties away from zero and saturated, plus a singular and an overflow flag.
// An accepted input transaction passes through two adjugate stages, three
// multiply-and-sum stages, two divider set-up stages, 33 quotient stages (one bit
// each) and the output register before its result is presented.
// Throughput is one transaction per cycle unless held; the 33-stage divider sets the depth.
// The whole pipeline advances together. It only holds when the output register
// has a result that the receiver does not take; in that case in_tready drops in
// the same cycle and nothing inside is lost or repeated. Bubbles travel with
// their own valid bits and stay where they are while the output is held.
// After reset (rst_n low, synchronous) all valid bits are clear and the block
// accepts input at once. The block keeps no state between transactions.
// A zero determinant gives singular = 1 with zero outputs and overflow = 0.
module solve_3x3_linear_system_core (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // h_00, h_01, h_02, h_10, h_11, h_12, h_20, h_21, h_22, d_0, d_1, d_2 (24 bits each)
  input  logic [287:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // b_0, b_1, b_2 (32 bits each)
  output logic [95:0]  out_tdata,
  // singular, overflow
  output logic [1:0]   out_tuser
);
  import slv3_pkg::*;

  logic      en;
  hmat_t     h_in;
  vec3_t     d_in;
  logic      adj_v;
  adjm_t     adj;
  vec3_t     hrow, dvec;
  logic      mac_v;
  logic [SUM_W-1:0]       det;
  logic [2:0][SUM_W-1:0]  num;
  logic      [2:0] lane_v;
  lane_res_t lane_res [3];

  // Global advance: the pipeline moves unless a finished result is held.
  // No input transaction is taken while reset is asserted.
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en && rst_n;

  always_comb begin
    for (int k = 0; k < 9; k++) begin
      h_in[k] = in_tdata[k*DW +: DW];
    end
    for (int k = 0; k < 3; k++) begin
      d_in[k] = in_tdata[(9+k)*DW +: DW];
    end
  end

  slv3_adj u_adj (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_tvalid),
    .h         (h_in),
    .d         (d_in),
    .out_valid (adj_v),
    .adj       (adj),
    .hrow      (hrow),
    .dvec      (dvec)
  );

  slv3_mac u_mac (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (adj_v),
    .adj       (adj),
    .hrow      (hrow),
    .dvec      (dvec),
    .out_valid (mac_v),
    .det       (det),
    .num       (num)
  );

  // Three identical lanes, one for each solution element.
  for (genvar i = 0; i < 3; i++) begin : g_lane
    slv3_div u_div (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (en),
      .in_valid  (mac_v),
      .num       (num[i]),
      .det       (det),
      .out_valid (lane_v[i]),
      .res       (lane_res[i])
    );
  end

  assign out_tvalid = &lane_v;
  assign out_tdata  = {lane_res[2].b, lane_res[1].b, lane_res[0].b};
  assign out_tuser  = {lane_res[0].ovf | lane_res[1].ovf | lane_res[2].ovf,
                       lane_res[0].sing};

  // A singular result carries zero elements and no overflow.
  a_singular_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[0]) |-> (out_tdata == '0 && !out_tuser[1]))
    else $error("singular result with nonzero payload");

  // Overflow means at least one element sits at a saturation limit.
  a_overflow_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[1]) |->
      (out_tdata[30:0] == '1 || out_tdata[31:0] == 32'h8000_0000 ||
       out_tdata[62:32] == '1 || out_tdata[63:32] == 32'h8000_0000 ||
       out_tdata[94:64] == '1 || out_tdata[95:64] == 32'h8000_0000))
    else $error("overflow flag without a saturated element");

  // The three lanes advance in lock step.
  a_lanes_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    (lane_v[0] == lane_v[1]) && (lane_v[1] == lane_v[2]))
    else $error("solution lanes out of step");

  // Nothing is presented in the cycle after a reset cycle.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result presented straight after reset");

endmodule
